// ===== design/kcsd_pkg.sv =====
package kcsd_pkg;

  // default parameter values
  localparam int MAX_KEYS_DEF      = 4;
  localparam int KEY_CODE_BITS_DEF = 9;

  // register widths
  localparam int KEY_REG_BITS   = 9;
  localparam int COUNT_BITS     = 3;
  localparam int TICK_BITS      = 16;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;
  localparam int SEQ_IDX_BITS   = 2;
  localparam int NUM_KEY_REGS   = 4;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_0         = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_1         = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_2         = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_3         = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_COUNT     = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SEQUENCE_MODE = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_REPEAT_ENABLE = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAP_LIMIT     = 3'd7;

  // operation codes
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // reset values
  localparam logic [COUNT_BITS-1:0] KEY_COUNT_RST = 3'd1;
  localparam logic [TICK_BITS-1:0]  GAP_LIMIT_RST = 16'd1000;
  localparam logic [TICK_BITS-1:0]  TICK_MAX      = 16'hFFFF;

endpackage

// ===== design/key_chord_sequence_detector.sv =====
// channel  ports                                          direction
// in       in_valid/in_ready, in_operation, in_key_code,  to block
//          in_key_down
// out      out_valid/out_ready, out_fired,                from block
//          out_chord_pressed
// cfg      cfg_valid/cfg_ready, cfg_index, cfg_data       to block
//
// one word accepted per cycle while in_ready is high; its result is registered
// in the output register at the accepting edge, as are all state updates
// in_ready drops only while a result is held and out_ready is low
// cfg_ready is always high; a write is registered at the edge that accepts it
// synchronous active-low reset clears state and output valid, and sets registers to defaults
module key_chord_sequence_detector
  import kcsd_pkg::*;
#(
  parameter int MAX_KEYS      = MAX_KEYS_DEF,
  parameter int KEY_CODE_BITS = KEY_CODE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_operation,
  input  logic [KEY_CODE_BITS-1:0]  in_key_code,
  input  logic                      in_key_down,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_fired,
  output logic                      out_chord_pressed,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  // configuration registers
  logic [KEY_REG_BITS-1:0] key_r [NUM_KEY_REGS];
  logic [COUNT_BITS-1:0]   key_count_r;
  logic                    sequence_mode_r;
  logic                    repeat_enable_r;
  logic [TICK_BITS-1:0]    gap_limit_r;

  // detector state
  logic [MAX_KEYS-1:0]     slot_down_r, slot_down_nxt;
  logic                    chord_r, chord_nxt;
  logic [SEQ_IDX_BITS-1:0] seq_idx_r, seq_idx_nxt;
  logic [TICK_BITS-1:0]    ticks_r, ticks_nxt;
  logic                    fired_nxt;

  // output register
  logic out_valid_r;
  logic out_fired_r;
  logic out_chord_r;

  logic                    in_fire;
  logic [COUNT_BITS-1:0]   n_slots;
  logic [KEY_CODE_BITS-1:0] key_ext [NUM_KEY_REGS];
  logic [NUM_KEY_REGS-1:0] key_hit;
  logic [MAX_KEYS-1:0]     slot_use;
  logic [MAX_KEYS-1:0]     slot_hit;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;

  assign out_valid         = out_valid_r;
  assign out_fired         = out_fired_r;
  assign out_chord_pressed = out_chord_r;

  // slots in use, clamped to 1..MAX_KEYS
  always_comb begin
    if (key_count_r == '0) begin
      n_slots = COUNT_BITS'(1);
    end else if (key_count_r > COUNT_BITS'(MAX_KEYS)) begin
      n_slots = COUNT_BITS'(MAX_KEYS);
    end else begin
      n_slots = key_count_r;
    end
  end

  // key codes brought to compare width and matched against the event
  for (genvar k = 0; k < NUM_KEY_REGS; k++) begin : g_key
    for (genvar b = 0; b < KEY_CODE_BITS; b++) begin : g_bit
      if (b < KEY_REG_BITS) begin : g_in
        assign key_ext[k][b] = key_r[k][b];
      end else begin : g_pad
        assign key_ext[k][b] = 1'b0;
      end
    end
    assign key_hit[k] = (key_ext[k] == in_key_code);
  end

  for (genvar i = 0; i < MAX_KEYS; i++) begin : g_slot
    assign slot_use[i] = (COUNT_BITS'(i) < n_slots);
    assign slot_hit[i] = slot_use[i] && key_hit[i];
  end

  // next state for one word
  always_comb begin
    logic                    all_down;
    logic                    matched;
    logic                    step;
    logic [SEQ_IDX_BITS-1:0] idx;

    slot_down_nxt = slot_down_r;
    chord_nxt     = chord_r;
    seq_idx_nxt   = seq_idx_r;
    ticks_nxt     = ticks_r;
    fired_nxt     = 1'b0;
    all_down      = 1'b1;
    matched       = |slot_hit;
    step          = 1'b0;
    idx           = seq_idx_r;

    if (in_operation == OP_TICK) begin
      if (ticks_r != TICK_MAX) begin
        ticks_nxt = ticks_r + TICK_BITS'(1);
      end
    end else begin
      // slot flags follow every matching slot
      for (int i = 0; i < MAX_KEYS; i++) begin
        if (slot_hit[i]) begin
          slot_down_nxt[i] = in_key_down;
        end
        if (slot_use[i] && !slot_down_nxt[i]) begin
          all_down = 1'b0;
        end
      end

      if (!sequence_mode_r) begin
        // chord: report on change, or always with repeat
        if ((all_down != chord_r) || repeat_enable_r) begin
          chord_nxt = all_down;
          fired_nxt = 1'b1;
        end
      end else begin
        // stale index after key count was lowered restarts at zero
        if ({1'b0, seq_idx_r} >= n_slots) begin
          idx = '0;
        end
        seq_idx_nxt = idx;
        step = ((idx == '0) || (ticks_r < gap_limit_r)) && matched && in_key_down
               && key_hit[idx];
        // start key restarts the sequence
        if (!step && in_key_down && key_hit[0]) begin
          idx  = '0;
          step = 1'b1;
        end
        chord_nxt = 1'b0;
        if (step && ({1'b0, idx} == n_slots - COUNT_BITS'(1))) begin
          chord_nxt   = 1'b1;
          seq_idx_nxt = '0;
          ticks_nxt   = '0;
          fired_nxt   = 1'b1;
        end else if (step) begin
          seq_idx_nxt = idx + SEQ_IDX_BITS'(1);
          ticks_nxt   = '0;
        end else if (in_key_down) begin
          seq_idx_nxt = '0;
        end
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_KEY_REGS; k++) begin
        key_r[k] <= '0;
      end
      key_count_r     <= KEY_COUNT_RST;
      sequence_mode_r <= 1'b0;
      repeat_enable_r <= 1'b0;
      gap_limit_r     <= GAP_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_KEY_0:         key_r[0]        <= cfg_data[KEY_REG_BITS-1:0];
        REG_KEY_1:         key_r[1]        <= cfg_data[KEY_REG_BITS-1:0];
        REG_KEY_2:         key_r[2]        <= cfg_data[KEY_REG_BITS-1:0];
        REG_KEY_3:         key_r[3]        <= cfg_data[KEY_REG_BITS-1:0];
        REG_KEY_COUNT:     key_count_r     <= cfg_data[COUNT_BITS-1:0];
        REG_SEQUENCE_MODE: sequence_mode_r <= cfg_data[0];
        REG_REPEAT_ENABLE: repeat_enable_r <= cfg_data[0];
        REG_GAP_LIMIT:     gap_limit_r     <= cfg_data[TICK_BITS-1:0];
        default: ;
      endcase
    end
  end

  // state update on an accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_down_r <= '0;
      chord_r     <= 1'b0;
      seq_idx_r   <= '0;
      ticks_r     <= '0;
    end else if (in_fire) begin
      slot_down_r <= slot_down_nxt;
      chord_r     <= chord_nxt;
      seq_idx_r   <= seq_idx_nxt;
      ticks_r     <= ticks_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_fired_r <= fired_nxt;
      out_chord_r <= chord_nxt;
    end
  end

endmodule

// ===== design/kcsd_checker.sv =====
module kcsd_checker
  import kcsd_pkg::*;
#(
  parameter int KEY_CODE_BITS = KEY_CODE_BITS_DEF
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      in_operation,
  input logic [KEY_CODE_BITS-1:0]  in_key_code,
  input logic                      in_key_down,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      out_fired,
  input logic                      out_chord_pressed,
  input logic                      cfg_valid,
  input logic                      cfg_ready,
  input logic [CFG_INDEX_BITS-1:0] cfg_index,
  input logic [CFG_DATA_BITS-1:0]  cfg_data
);

  // held result word keeps its fields
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_fired)
                                && $stable(out_chord_pressed))
    else $error("held result word changed");

  // every accepted word shows its result on the next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word produced no result");

  // a tick never fires
  a_tick_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_operation == OP_TICK) |=> !out_fired)
    else $error("tick word fired");

  // output register empty after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind key_chord_sequence_detector kcsd_checker #(
  .KEY_CODE_BITS(KEY_CODE_BITS)
) u_kcsd_checker (.*);

// ===== verif/key_chord_sequence_detector_tb.sv =====
module key_chord_sequence_detector_tb;
  import kcsd_pkg::*;

  localparam int CODE_W     = KEY_CODE_BITS_DEF;
  localparam int CYCLE_CAP  = 1_000_000;
  localparam int SHOW_LIMIT = 10;

  localparam logic [CFG_INDEX_BITS-1:0] KEY_REGS [NUM_KEY_REGS] =
    '{REG_KEY_0, REG_KEY_1, REG_KEY_2, REG_KEY_3};

  typedef struct packed {
    logic fired;
    logic chord_pressed;
  } chord_result_t;

  logic                      clk;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      in_operation = OP_KEY;
  logic [CODE_W-1:0]         in_key_code = '0;
  logic                      in_key_down = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      out_fired;
  logic                      out_chord_pressed;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  // predictor copy of registers and state
  logic [CODE_W-1:0]       key_cfg [NUM_KEY_REGS] = '{default: '0};
  logic [COUNT_BITS-1:0]   count_cfg = KEY_COUNT_RST;
  logic                    seq_cfg = 1'b0;
  logic                    repeat_cfg = 1'b0;
  logic [TICK_BITS-1:0]    gap_cfg = GAP_LIMIT_RST;
  logic                    slot_down [NUM_KEY_REGS] = '{default: 1'b0};
  logic                    chord_q = 1'b0;
  logic [SEQ_IDX_BITS-1:0] seq_pos = '0;
  logic [TICK_BITS-1:0]    idle_ticks = '0;

  chord_result_t pending_chord_q [$];
  chord_result_t next_chord;
  int            words_sent = 0;
  int            results_seen = 0;
  int            fail_count = 0;
  int            cycle_count = 0;
  int            sender_idle_pct = 0;
  int            recv_stall_pct = 0;
  int            hold_cycles = 0;

  key_chord_sequence_detector dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_key_code       (in_key_code),
    .in_key_down       (in_key_down),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_fired         (out_fired),
    .out_chord_pressed (out_chord_pressed),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_CAP) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[key_chord_sequence_detector] ERROR");
    $finish;
  end

  // number of slots in use after clamping the count register
  function automatic int slots_active();
    if (count_cfg == 0) return 1;
    if (count_cfg > MAX_KEYS_DEF) return MAX_KEYS_DEF;
    return count_cfg;
  endfunction

  // expected result of one word, updates the predictor state
  function automatic chord_result_t predict_chord(input logic op, input logic [CODE_W-1:0] code,
                                                  input logic down);
    chord_result_t r;
    int            n;
    int            i;
    logic          matched;
    logic          all_down;
    logic          advance;
    r.fired = 1'b0;
    n = slots_active();
    matched = 1'b0;
    if (op == OP_TICK) begin
      if (idle_ticks != TICK_MAX) idle_ticks = idle_ticks + 1'b1;
    end else begin
      for (i = 0; i < n; i++) begin
        if (key_cfg[i] == code) begin
          slot_down[i] = down;
          matched = 1'b1;
        end
      end
      if (!seq_cfg) begin
        // chord: report on change of the all-down state, or always with repeat
        all_down = 1'b1;
        for (i = 0; i < n; i++) begin
          if (!slot_down[i]) all_down = 1'b0;
        end
        if (all_down != chord_q || repeat_cfg) begin
          chord_q = all_down;
          r.fired = 1'b1;
        end
      end else begin
        // sequence: step while presses stay inside the gap, first key restarts
        if (seq_pos >= n) seq_pos = '0;
        advance = (seq_pos == 0 || idle_ticks < gap_cfg) && matched && down &&
                  key_cfg[seq_pos] == code;
        if (!advance && down && key_cfg[0] == code) begin
          seq_pos = '0;
          advance = 1'b1;
        end
        if (advance && seq_pos == n - 1) begin
          chord_q = 1'b1;
          seq_pos = '0;
          idle_ticks = '0;
          r.fired = 1'b1;
        end else begin
          if (advance) begin
            seq_pos = seq_pos + 1'b1;
            idle_ticks = '0;
          end else if (down) begin
            seq_pos = '0;
          end
          chord_q = 1'b0;
        end
      end
    end
    r.chord_pressed = chord_q;
    return r;
  endfunction

  task automatic flag_error(input string msg);
    fail_count++;
    if (fail_count <= SHOW_LIMIT) $display("mismatch: %s", msg);
  endtask

  // offer one word, valid stays high on return so back-to-back words need no toggle
  task automatic send_word(input logic op, input logic [CODE_W-1:0] code, input logic down);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_key_code  <= code;
    in_key_down  <= down;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_chord_q.insert(pending_chord_q.size(), predict_chord(op, code, down));
    words_sent++;
  endtask

  task automatic send_tick();
    send_word(OP_TICK, CODE_W'($urandom_range(511)), 1'($urandom_range(1)));
  endtask

  // drop valid and let every expected word arrive
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_chord_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_KEY_0, REG_KEY_1, REG_KEY_2, REG_KEY_3: key_cfg[idx] = data[CODE_W-1:0];
      REG_KEY_COUNT:     count_cfg = data[COUNT_BITS-1:0];
      REG_SEQUENCE_MODE: seq_cfg = data[0];
      REG_REPEAT_ENABLE: repeat_cfg = data[0];
      REG_GAP_LIMIT:     gap_cfg = data[TICK_BITS-1:0];
      default: ;
    endcase
  endtask

  // check every accepted result against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_chord_q.size() == 0) begin
        flag_error($sformatf("unexpected word %0d fired=%0b chord=%0b",
                             results_seen, out_fired, out_chord_pressed));
      end else begin
        next_chord = pending_chord_q.pop_front();
        if (out_fired !== next_chord.fired)
          flag_error($sformatf("word %0d fired expected %0b got %0b",
                               results_seen, next_chord.fired, out_fired));
        if (out_chord_pressed !== next_chord.chord_pressed)
          flag_error($sformatf("word %0d chord_pressed expected %0b got %0b",
                               results_seen, next_chord.chord_pressed, out_chord_pressed));
      end
      results_seen++;
    end
  end

  // receiver: random stalls, or a counted hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles != 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // reset registers, single slot on code zero
  task automatic test_reset_defaults();
    send_word(OP_KEY, '0, 1'b1);
    send_word(OP_KEY, '0, 1'b1);
    send_tick();
    send_word(OP_KEY, '1, 1'b0);
    send_word(OP_KEY, '0, 1'b0);
    wait_idle();
  endtask

  // four-key chord with extreme codes, then repeat mode
  task automatic test_chord();
    write_reg(REG_KEY_0, 16'd0);
    write_reg(REG_KEY_1, 16'd511);
    write_reg(REG_KEY_2, 16'h0AA);
    write_reg(REG_KEY_3, 16'h155);
    write_reg(REG_KEY_COUNT, 16'd4);
    write_reg(REG_SEQUENCE_MODE, 16'd0);
    write_reg(REG_REPEAT_ENABLE, 16'd0);
    send_word(OP_KEY, 9'd0, 1'b1);
    send_word(OP_KEY, 9'd511, 1'b1);
    send_word(OP_KEY, 9'h0AA, 1'b1);
    send_word(OP_KEY, 9'h155, 1'b1);
    send_word(OP_KEY, 9'd511, 1'b0);
    wait_idle();
    write_reg(REG_REPEAT_ENABLE, 16'd1);
    send_word(OP_KEY, 9'd511, 1'b1);
    send_word(OP_KEY, 9'd511, 1'b1);
    wait_idle();
    write_reg(REG_REPEAT_ENABLE, 16'd0);
  endtask

  // count register outside 1..4, and two slots sharing a code
  task automatic test_count_clamp();
    write_reg(REG_KEY_COUNT, 16'd0);
    send_word(OP_KEY, 9'h155, 1'b0);
    send_word(OP_KEY, 9'd0, 1'b0);
    wait_idle();
    write_reg(REG_KEY_COUNT, 16'd7);
    write_reg(REG_KEY_3, 16'h0AA);
    send_word(OP_KEY, 9'd0, 1'b1);
    send_word(OP_KEY, 9'h0AA, 1'b0);
    wait_idle();
  endtask

  // ordered presses, late press, restart on first key, zero gap, mode switch
  task automatic test_sequence();
    write_reg(REG_KEY_0, 16'h011);
    write_reg(REG_KEY_1, 16'h022);
    write_reg(REG_KEY_2, 16'h033);
    write_reg(REG_KEY_COUNT, 16'd3);
    write_reg(REG_GAP_LIMIT, 16'd3);
    write_reg(REG_SEQUENCE_MODE, 16'd1);
    send_word(OP_KEY, 9'h011, 1'b1);
    send_tick();
    send_word(OP_KEY, 9'h022, 1'b1);
    send_word(OP_KEY, 9'h033, 1'b1);
    send_word(OP_KEY, 9'h011, 1'b1);
    repeat (3) send_tick();
    send_word(OP_KEY, 9'h022, 1'b1);
    send_word(OP_KEY, 9'h011, 1'b1);
    send_word(OP_KEY, 9'h011, 1'b1);
    send_word(OP_KEY, 9'h022, 1'b0);
    wait_idle();
    write_reg(REG_GAP_LIMIT, 16'd0);
    send_word(OP_KEY, 9'h011, 1'b1);
    send_word(OP_KEY, 9'h022, 1'b1);
    send_word(OP_KEY, 9'h011, 1'b1);
    wait_idle();
    // state survives the switch to chord mode and back
    write_reg(REG_SEQUENCE_MODE, 16'd0);
    write_reg(REG_GAP_LIMIT, 16'd3);
    send_word(OP_KEY, 9'h033, 1'b1);
    wait_idle();
    write_reg(REG_SEQUENCE_MODE, 16'd1);
    send_word(OP_KEY, 9'h022, 1'b1);
    wait_idle();
  endtask

  // sequence position left past a lowered key count
  task automatic test_stale_position();
    write_reg(REG_KEY_3, 16'h044);
    write_reg(REG_KEY_COUNT, 16'd4);
    send_word(OP_KEY, 9'h011, 1'b1);
    send_word(OP_KEY, 9'h022, 1'b1);
    send_word(OP_KEY, 9'h033, 1'b1);
    wait_idle();
    write_reg(REG_KEY_COUNT, 16'd2);
    send_word(OP_KEY, 9'h022, 1'b1);
    send_word(OP_KEY, 9'h011, 1'b1);
    send_word(OP_KEY, 9'h022, 1'b1);
    wait_idle();
  endtask

  // widest gap, then presses one tick inside and exactly at a short gap
  task automatic test_gap_boundary();
    write_reg(REG_GAP_LIMIT, 16'hFFFF);
    send_word(OP_KEY, 9'h011, 1'b1);
    repeat (40) send_tick();
    send_word(OP_KEY, 9'h022, 1'b1);
    wait_idle();
    write_reg(REG_KEY_COUNT, 16'd3);
    write_reg(REG_GAP_LIMIT, 16'd5);
    send_word(OP_KEY, 9'h011, 1'b1);
    repeat (4) send_tick();
    send_word(OP_KEY, 9'h022, 1'b1);
    repeat (5) send_tick();
    send_word(OP_KEY, 9'h033, 1'b1);
    send_word(OP_KEY, 9'h011, 1'b1);
    repeat (4) send_tick();
    send_word(OP_KEY, 9'h022, 1'b1);
    repeat (4) send_tick();
    send_word(OP_KEY, 9'h033, 1'b1);
    wait_idle();
  endtask

  // receiver holds off while words keep coming, then sender waits for drain
  task automatic test_backpressure();
    int i;
    write_reg(REG_SEQUENCE_MODE, 16'd0);
    write_reg(REG_REPEAT_ENABLE, 16'd1);
    hold_cycles = 80;
    for (i = 0; i < 30; i++) send_word(OP_KEY, key_cfg[$urandom_range(3)], 1'($urandom_range(1)));
    wait_idle();
    for (i = 0; i < 10; i++) send_tick();
    wait_idle();
  endtask

  task automatic pick_setup();
    int                i;
    int                pick;
    logic [CODE_W-1:0] code;
    for (i = 0; i < NUM_KEY_REGS; i++) begin
      pick = $urandom_range(99);
      if (i > 0 && pick < 20) code = key_cfg[$urandom_range(i - 1)];
      else if (pick < 30) code = '0;
      else if (pick < 40) code = '1;
      else code = CODE_W'($urandom_range(511));
      write_reg(KEY_REGS[i], CFG_DATA_BITS'(code));
    end
    pick = $urandom_range(99);
    if (pick < 8) write_reg(REG_KEY_COUNT, 16'd0);
    else if (pick < 16) write_reg(REG_KEY_COUNT, CFG_DATA_BITS'($urandom_range(7, 5)));
    else write_reg(REG_KEY_COUNT, CFG_DATA_BITS'($urandom_range(4, 1)));
    write_reg(REG_SEQUENCE_MODE, CFG_DATA_BITS'($urandom_range(1)));
    write_reg(REG_REPEAT_ENABLE, CFG_DATA_BITS'($urandom_range(1)));
    pick = $urandom_range(99);
    if (pick < 5) write_reg(REG_GAP_LIMIT, 16'd0);
    else if (pick < 10) write_reg(REG_GAP_LIMIT, 16'hFFFF);
    else if (pick < 15) write_reg(REG_GAP_LIMIT, CFG_DATA_BITS'($urandom_range(65535)));
    else write_reg(REG_GAP_LIMIT, CFG_DATA_BITS'($urandom_range(6, 1)));
  endtask

  // noise word: tick, stray code, or a configured key
  task automatic send_random_word();
    int pick;
    pick = $urandom_range(99);
    if (pick < 20) send_tick();
    else if (pick < 35) send_word(OP_KEY, CODE_W'($urandom_range(511)), 1'($urandom_range(1)));
    else send_word(OP_KEY, key_cfg[$urandom_range(3)], $urandom_range(99) < 60);
  endtask

  // presses in slot order with short tick runs, sometimes broken by noise
  task automatic send_sequence_run();
    int n;
    int s;
    int span;
    n = slots_active();
    span = (gap_cfg != 0 && gap_cfg <= 4) ? int'(gap_cfg) : 3;
    for (s = 0; s < n; s++) begin
      if ($urandom_range(99) < 10) send_random_word();
      repeat ($urandom_range(span)) send_tick();
      send_word(OP_KEY, key_cfg[s], 1'b1);
      if ($urandom_range(1)) send_word(OP_KEY, key_cfg[s], 1'b0);
    end
  endtask

  task automatic test_random_traffic();
    int phase;
    int batch;
    int start;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin sender_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      for (batch = 0; batch < 8; batch++) begin
        pick_setup();
        start = words_sent;
        while (words_sent - start < 48) begin
          if (seq_cfg && $urandom_range(99) < 70) send_sequence_run();
          else send_random_word();
        end
        wait_idle();
      end
    end
    sender_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_chord();
    test_count_clamp();
    test_sequence();
    test_stale_position();
    test_gap_boundary();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    repeat (4) @(posedge clk);
    if (pending_chord_q.size() != 0)
      flag_error($sformatf("%0d words never arrived", pending_chord_q.size()));
    if (fail_count == 0) begin
      $display("[key_chord_sequence_detector] OK");
    end else begin
      $display("[key_chord_sequence_detector] ERROR");
    end
    $finish;
  end

endmodule
